// ----- sv/cau_pkg.sv -----
// cau_pkg: widths, operation codes, pipeline word types and saturation helpers
// for the complex arithmetic unit; depends on nothing
`default_nettype none

package cau_pkg;

  // word and fraction widths of the fixed-point operands
  localparam int W   = 32;
  localparam int F   = 16;
  // full product, sum of two products, magnitude scratch width
  localparam int PW  = 2 * W;
  localparam int SW  = PW + 1;
  localparam int MW  = PW + 2;
  // quotient bits kept, scaled dividend width, shifted divisor compare width
  localparam int QB  = W + 1;
  localparam int NW  = PW + F;
  localparam int CW  = PW + QB;
  // cycles from an accepted word to its result strobe
  localparam int LAT = QB + 5;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_CONJ = 3'd5,
    OP_MAG  = 3'd6
  } op_t;

  // registered operands
  typedef struct packed {
    logic               valid;
    logic [2:0]         op;
    logic signed [W-1:0] ar;
    logic signed [W-1:0] ai;
    logic signed [W-1:0] br;
    logic signed [W-1:0] bi;
  } in_stage_t;

  // products plus operands for the add family
  typedef struct packed {
    logic                 valid;
    logic [2:0]           op;
    logic signed [W-1:0]  ar;
    logic signed [W-1:0]  ai;
    logic signed [W-1:0]  br;
    logic signed [W-1:0]  bi;
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p3;
    logic signed [PW-1:0] p4;
    logic signed [PW-1:0] p5;
  } prod_stage_t;

  // exact real and imaginary sums, divisor
  typedef struct packed {
    logic                 valid;
    logic [2:0]           op;
    logic signed [SW-1:0] x_re;
    logic signed [SW-1:0] x_im;
    logic [PW-1:0]        d;
  } sum_stage_t;

  // word carried through the divide and square root steps
  typedef struct packed {
    logic          valid;
    logic [2:0]    op;
    logic          dz;
    logic          sat;
    logic [W-1:0]  res_re;
    logic [W-1:0]  res_im;
    logic [PW-1:0] d;
    logic          neg_r;
    logic          neg_i;
    logic          ovf_r;
    logic          ovf_i;
    logic [NW-1:0] rem_r;
    logic [NW-1:0] rem_i;
    logic [QB-1:0] q_r;
    logic [QB-1:0] q_i;
    logic [PW-1:0] sq_rem;
    logic [W-1:0]  root;
  } iter_stage_t;

  // magnitude of a signed sum
  function automatic logic [MW-1:0] abs_mag(input logic signed [SW-1:0] x);
    logic [MW-1:0] e;
    e = MW'(x);
    return x[SW-1] ? -e : e;
  endfunction

  // clip sign and magnitude to the word range, returns {clipped, word}
  function automatic logic [W:0] emit(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] lim;
    logic [MW-1:0] m;
    logic          sat;
    lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    sat = mag > lim;
    m   = sat ? lim : mag;
    m   = neg ? -m : m;
    return {sat, m[W-1:0]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/complex_arithmetic_unit_top.sv -----
// complex_arithmetic_unit_top: pipelined complex add, subtract, multiply, divide,
// negate, conjugate and magnitude on signed Q16.16; depends on cau_pkg
//
// channel   ports                                      handshake
// input     in_operation, in_a_*, in_b_*               start high while busy low
// result    out_res_*, out_div_zero, out_saturated     out_valid, one cycle strobe
//
// one word enters every cycle; busy is always low
// the pipeline depth is set by the 33 one-bit divide steps (the square
// root runs its 32 bit steps in the same stages)
// stages: input, products, sums, setup, 33 divide/root steps, result
// synchronous active-low reset clears the valid bits only
// the receiver cannot stall, so the pipeline always advances
`default_nettype none

module complex_arithmetic_unit_top
  import cau_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          in_operation,
  input  wire logic signed [W-1:0] in_a_real,
  input  wire logic signed [W-1:0] in_a_imag,
  input  wire logic signed [W-1:0] in_b_real,
  input  wire logic signed [W-1:0] in_b_imag,
  output logic                     out_valid,
  output logic signed [W-1:0]      out_res_real,
  output logic signed [W-1:0]      out_res_imag,
  output logic                     out_div_zero,
  output logic                     out_saturated
);

  in_stage_t   s0_r;
  prod_stage_t s1_r, s1_nxt;
  sum_stage_t  s2_r, s2_nxt;
  iter_stage_t it_r [0:QB];
  iter_stage_t setup_nxt;

  logic           out_valid_r;
  logic [W-1:0]   out_re_r, out_re_nxt;
  logic [W-1:0]   out_im_r, out_im_nxt;
  logic           out_dz_r, out_dz_nxt;
  logic           out_sat_r, out_sat_nxt;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else begin
      s0_r.valid <= start;
      s0_r.op    <= in_operation;
      s0_r.ar    <= in_a_real;
      s0_r.ai    <= in_a_imag;
      s0_r.br    <= in_b_real;
      s0_r.bi    <= in_b_imag;
    end
  end

  // six products; magnitude squares the first operand parts
  always_comb begin
    logic signed [W-1:0] m0;
    logic signed [W-1:0] m1;
    m0 = (s0_r.op == OP_MAG) ? s0_r.ar : s0_r.br;
    m1 = (s0_r.op == OP_MAG) ? s0_r.ai : s0_r.bi;
    s1_nxt.valid = s0_r.valid;
    s1_nxt.op    = s0_r.op;
    s1_nxt.ar    = s0_r.ar;
    s1_nxt.ai    = s0_r.ai;
    s1_nxt.br    = s0_r.br;
    s1_nxt.bi    = s0_r.bi;
    s1_nxt.p0    = s0_r.ar * m0;
    s1_nxt.p1    = s0_r.ai * m1;
    s1_nxt.p2    = s0_r.ar * s0_r.bi;
    s1_nxt.p3    = s0_r.ai * s0_r.br;
    s1_nxt.p4    = s0_r.br * s0_r.br;
    s1_nxt.p5    = s0_r.bi * s0_r.bi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_r.valid <= 1'b0;
    else        s1_r <= s1_nxt;
  end

  // exact sums per operation
  always_comb begin
    s2_nxt.valid = s1_r.valid;
    s2_nxt.op    = s1_r.op;
    s2_nxt.d     = PW'(s1_r.p4) + PW'(s1_r.p5);
    s2_nxt.x_re  = '0;
    s2_nxt.x_im  = '0;
    unique case (s1_r.op)
      OP_ADD: begin
        s2_nxt.x_re = SW'(s1_r.ar) + SW'(s1_r.br);
        s2_nxt.x_im = SW'(s1_r.ai) + SW'(s1_r.bi);
      end
      OP_SUB: begin
        s2_nxt.x_re = SW'(s1_r.ar) - SW'(s1_r.br);
        s2_nxt.x_im = SW'(s1_r.ai) - SW'(s1_r.bi);
      end
      OP_MUL: begin
        s2_nxt.x_re = SW'(s1_r.p0) - SW'(s1_r.p1);
        s2_nxt.x_im = SW'(s1_r.p2) + SW'(s1_r.p3);
      end
      OP_DIV: begin
        s2_nxt.x_re = SW'(s1_r.p0) + SW'(s1_r.p1);
        s2_nxt.x_im = SW'(s1_r.p3) - SW'(s1_r.p2);
      end
      OP_NEG: begin
        s2_nxt.x_re = -SW'(s1_r.ar);
        s2_nxt.x_im = -SW'(s1_r.ai);
      end
      OP_CONJ: begin
        s2_nxt.x_re = SW'(s1_r.ar);
        s2_nxt.x_im = -SW'(s1_r.ai);
      end
      OP_MAG: begin
        s2_nxt.x_re = SW'(s1_r.p0) + SW'(s1_r.p1);
      end
      default: begin
        s2_nxt.x_re = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_r.valid <= 1'b0;
    else        s2_r <= s2_nxt;
  end

  // finish the simple ops, set up divide and square root
  always_comb begin
    logic [MW-1:0] mag_re;
    logic [MW-1:0] mag_im;
    logic [W:0]    e_re;
    logic [W:0]    e_im;
    mag_re = abs_mag(s2_r.x_re);
    mag_im = abs_mag(s2_r.x_im);
    e_re   = '0;
    e_im   = '0;
    setup_nxt        = '0;
    setup_nxt.valid  = s2_r.valid;
    setup_nxt.op     = s2_r.op;
    setup_nxt.d      = s2_r.d;
    setup_nxt.neg_r  = s2_r.x_re[SW-1];
    setup_nxt.neg_i  = s2_r.x_im[SW-1];
    setup_nxt.rem_r  = NW'(mag_re[PW-1:0]) << F;
    setup_nxt.rem_i  = NW'(mag_im[PW-1:0]) << F;
    setup_nxt.ovf_r  = CW'(setup_nxt.rem_r) >= (CW'(s2_r.d) << QB);
    setup_nxt.ovf_i  = CW'(setup_nxt.rem_i) >= (CW'(s2_r.d) << QB);
    setup_nxt.sq_rem = s2_r.x_re[PW-1:0];
    unique case (s2_r.op)
      OP_ADD, OP_SUB, OP_NEG, OP_CONJ: begin
        e_re = emit(s2_r.x_re[SW-1], mag_re);
        e_im = emit(s2_r.x_im[SW-1], mag_im);
      end
      OP_MUL: begin
        e_re = emit(s2_r.x_re[SW-1], (mag_re + (MW'(1) << (F - 1))) >> F);
        e_im = emit(s2_r.x_im[SW-1], (mag_im + (MW'(1) << (F - 1))) >> F);
      end
      OP_DIV: begin
        setup_nxt.dz = (s2_r.d == '0);
      end
      default: begin
        e_re = '0;
      end
    endcase
    setup_nxt.sat    = e_re[W] | e_im[W];
    setup_nxt.res_re = e_re[W-1:0];
    setup_nxt.res_im = e_im[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) it_r[0].valid <= 1'b0;
    else        it_r[0] <= setup_nxt;
  end

  // one quotient bit per stage and one root bit in every stage but the first, most significant first
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    iter_stage_t stage_nxt;

    always_comb begin
      logic [CW-1:0] t_r;
      logic [CW-1:0] t_i;
      logic [MW-1:0] term;
      stage_nxt = it_r[j];
      t_r = CW'(it_r[j].d) << K;
      t_i = CW'(it_r[j].d) << K;
      // restoring divide step
      if (CW'(it_r[j].rem_r) >= t_r) begin
        stage_nxt.rem_r  = NW'(CW'(it_r[j].rem_r) - t_r);
        stage_nxt.q_r[K] = 1'b1;
      end
      if (CW'(it_r[j].rem_i) >= t_i) begin
        stage_nxt.rem_i  = NW'(CW'(it_r[j].rem_i) - t_i);
        stage_nxt.q_i[K] = 1'b1;
      end
      // square root step on the remainder of n minus root squared
      term = '0;
      if (K < W) begin
        term = (MW'(it_r[j].root) << (K + 1)) | (MW'(1) << (2 * K));
        if (MW'(it_r[j].sq_rem) >= term) begin
          stage_nxt.sq_rem = it_r[j].sq_rem - term[PW-1:0];
          stage_nxt.root   = it_r[j].root | W'(MW'(1) << K);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) it_r[j+1].valid <= 1'b0;
      else        it_r[j+1] <= stage_nxt;
    end
  end

  // round the quotients, clip, select the result word
  always_comb begin
    logic          up_r;
    logic          up_i;
    logic [QB:0]   qq_r;
    logic [QB:0]   qq_i;
    logic [W:0]    e_re;
    logic [W:0]    e_im;
    up_r = {1'b0, it_r[QB].rem_r, 1'b0} >= (NW + 2)'(it_r[QB].d);
    up_i = {1'b0, it_r[QB].rem_i, 1'b0} >= (NW + 2)'(it_r[QB].d);
    qq_r = (QB + 1)'(it_r[QB].q_r) + (QB + 1)'(up_r);
    qq_i = (QB + 1)'(it_r[QB].q_i) + (QB + 1)'(up_i);
    e_re = emit(it_r[QB].neg_r, it_r[QB].ovf_r ? '1 : MW'(qq_r));
    e_im = emit(it_r[QB].neg_i, it_r[QB].ovf_i ? '1 : MW'(qq_i));
    out_dz_nxt  = it_r[QB].dz;
    out_re_nxt  = it_r[QB].res_re;
    out_im_nxt  = it_r[QB].res_im;
    out_sat_nxt = it_r[QB].sat;
    if (it_r[QB].op == OP_DIV && !it_r[QB].dz) begin
      out_re_nxt  = e_re[W-1:0];
      out_im_nxt  = e_im[W-1:0];
      out_sat_nxt = e_re[W] | e_im[W];
    end else if (it_r[QB].op == OP_MAG) begin
      e_re        = emit(1'b0, MW'(it_r[QB].root));
      out_re_nxt  = e_re[W-1:0];
      out_im_nxt  = '0;
      out_sat_nxt = e_re[W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= it_r[QB].valid;
      out_re_r    <= out_re_nxt;
      out_im_r    <= out_im_nxt;
      out_dz_r    <= out_dz_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_res_real  = out_re_r;
  assign out_res_imag  = out_im_r;
  assign out_div_zero  = out_dz_r;
  assign out_saturated = out_sat_r;

  // zero divisor gives a clean zero word
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_res_real == '0 && out_res_imag == '0 && !out_saturated)
    else $error("zero divisor result not cleared");

  // divide flag only from divide words
  a_dz_op: assert property (@(posedge clk) disable iff (!rst_n)
    it_r[QB].valid && it_r[QB].dz |-> it_r[QB].op == OP_DIV)
    else $error("div_zero raised outside divide");

  // after the last step the remainder is below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    it_r[QB].valid && it_r[QB].op == OP_DIV && !it_r[QB].dz && !it_r[QB].ovf_r
    |-> PW'(it_r[QB].rem_r) < it_r[QB].d && it_r[QB].rem_r[NW-1:PW] == '0)
    else $error("divide remainder out of range");

endmodule

`default_nettype wire

// ----- tb/tb_complex_arithmetic_unit_top.sv -----
// tb_complex_arithmetic_unit_top: checks the complex arithmetic unit against its own
// fixed-point predictor, first with a short stimulus table, then with random words;
// depends on cau_pkg and complex_arithmetic_unit_top
`default_nettype none

module tb_complex_arithmetic_unit_top;
  import cau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1200;
  localparam int IDLE_LIMIT = 4000;

  typedef logic signed [127:0] wide_t;

  // one expected result word
  typedef struct {
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         dz;
    logic         sat;
  } cplx_res_t;

  // one row of the stimulus table; typed expectation used when fixed is set
  typedef struct {
    logic [2:0]   op;
    logic [W-1:0] ar;
    logic [W-1:0] ai;
    logic [W-1:0] br;
    logic [W-1:0] bi;
    logic         fixed;
    cplx_res_t    res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [2:0]          in_operation = '0;
  logic signed [W-1:0] in_a_real = '0;
  logic signed [W-1:0] in_a_imag = '0;
  logic signed [W-1:0] in_b_real = '0;
  logic signed [W-1:0] in_b_imag = '0;
  logic                out_valid;
  logic signed [W-1:0] out_res_real;
  logic signed [W-1:0] out_res_imag;
  logic                out_div_zero;
  logic                out_saturated;

  cplx_res_t pending_results[$];
  int        n_errors = 0;
  int        idle_cycles = 0;

  complex_arithmetic_unit_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation),
    .in_a_real(in_a_real), .in_a_imag(in_a_imag),
    .in_b_real(in_b_real), .in_b_imag(in_b_imag),
    .out_valid(out_valid),
    .out_res_real(out_res_real), .out_res_imag(out_res_imag),
    .out_div_zero(out_div_zero), .out_saturated(out_saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // clip to the word range, returns {clipped, word}
  function automatic logic [W:0] clip_word(input wide_t v);
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = (wide_t'(1) <<< (W - 1)) - 1;
    lo_lim = -(wide_t'(1) <<< (W - 1));
    if (v > hi_lim) return {1'b1, hi_lim[W-1:0]};
    if (v < lo_lim) return {1'b1, lo_lim[W-1:0]};
    return {1'b0, v[W-1:0]};
  endfunction

  // drop the fraction bits, nearest with ties away from zero
  function automatic wide_t round_frac(input wide_t x);
    wide_t m;
    m = (x < 0) ? -x : x;
    m = (m + (wide_t'(1) <<< (F - 1))) >>> F;
    return (x < 0) ? -m : m;
  endfunction

  // (x * 2^F) / d rounded to nearest, ties away from zero
  function automatic wide_t scaled_quot(input wide_t x, input wide_t d);
    wide_t m;
    wide_t q;
    wide_t r;
    m = ((x < 0) ? -x : x) <<< F;
    q = m / d;
    r = m % d;
    if ((r <<< 1) >= d) q = q + 1;
    return (x < 0) ? -q : q;
  endfunction

  // floor square root, result bit by bit
  function automatic wide_t floor_sqrt(input wide_t n);
    wide_t root;
    wide_t t;
    root = 0;
    for (int i = W; i >= 0; i--) begin
      t = root | (wide_t'(1) <<< i);
      if (t * t <= n) root = t;
    end
    return root;
  endfunction

  // expected result of one word
  function automatic cplx_res_t predict_cplx(input logic [2:0] op,
      input logic [W-1:0] a_re, input logic [W-1:0] a_im,
      input logic [W-1:0] b_re, input logic [W-1:0] b_im);
    wide_t ar;
    wide_t ai;
    wide_t br;
    wide_t bi;
    wide_t rr;
    wide_t ri;
    wide_t d;
    logic [W:0] cr;
    logic [W:0] ci;
    cplx_res_t res;
    ar = $signed(a_re);
    ai = $signed(a_im);
    br = $signed(b_re);
    bi = $signed(b_im);
    res = '{re: '0, im: '0, dz: 1'b0, sat: 1'b0};
    rr = 0;
    ri = 0;
    case (op)
      OP_ADD:  begin rr = ar + br; ri = ai + bi; end
      OP_SUB:  begin rr = ar - br; ri = ai - bi; end
      OP_MUL: begin
        rr = round_frac(ar * br - ai * bi);
        ri = round_frac(ar * bi + ai * br);
      end
      OP_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          res.dz = 1'b1;
          return res;
        end
        rr = scaled_quot(ar * br + ai * bi, d);
        ri = scaled_quot(ai * br - ar * bi, d);
      end
      OP_NEG:  begin rr = -ar; ri = -ai; end
      OP_CONJ: begin rr = ar; ri = -ai; end
      OP_MAG:  begin rr = floor_sqrt(ar * ar + ai * ai); ri = 0; end
      default: return res;
    endcase
    cr = clip_word(rr);
    ci = clip_word(ri);
    res.re  = cr[W-1:0];
    res.im  = ci[W-1:0];
    res.sat = cr[W] | ci[W];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
      input logic [W-1:0] want);
    n_errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // random operand: mostly moderate values, some full range, some extremes
  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2, 3:    return W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      4:       return W'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      5: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      default: return W'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  // drive one word after a random gap, return once it is taken
  task automatic send_word(input logic [2:0] op, input logic [W-1:0] ar,
      input logic [W-1:0] ai, input logic [W-1:0] br, input logic [W-1:0] bi,
      input cplx_res_t res);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_a_real    <= ar;
    in_a_imag    <= ai;
    in_b_real    <= br;
    in_b_imag    <= bi;
    do @(posedge clk); while (busy);
    pending_results.push_back(res);
  endtask

  // result check, words come out in order
  always @(posedge clk) begin
    cplx_res_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("unexpected result word at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        if (out_res_real !== want.re) report_mismatch("res_real", out_res_real, want.re);
        if (out_res_imag !== want.im) report_mismatch("res_imag", out_res_imag, want.im);
        if (out_div_zero !== want.dz)
          report_mismatch("div_zero", W'(out_div_zero), W'(want.dz));
        if (out_saturated !== want.sat)
          report_mismatch("saturated", W'(out_saturated), W'(want.sat));
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_complex_arithmetic_unit_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows[$];
    cplx_res_t none;
    cplx_res_t res;
    logic [2:0] op;
    logic [W-1:0] ar;
    logic [W-1:0] ai;
    logic [W-1:0] br;
    logic [W-1:0] bi;

    none = '{re: '0, im: '0, dz: 1'b0, sat: 1'b0};
    // extremes and special cases, typed results where obvious
    rows.push_back('{OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1}});
    rows.push_back('{OP_ADD, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0,
                     1'b1, '{32'h0003_0000, 32'h0, 1'b0, 1'b0}});
    rows.push_back('{OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                     1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1}});
    rows.push_back('{OP_NEG, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0,
                     1'b1, '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1}});
    rows.push_back('{OP_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0,
                     1'b1, '{32'h1234_5678, 32'h7FFF_FFFF, 1'b0, 1'b1}});
    rows.push_back('{OP_DIV, 32'h0005_0000, 32'h7FFF_FFFF, 32'h0, 32'h0,
                     1'b1, '{32'h0, 32'h0, 1'b1, 1'b0}});
    rows.push_back('{3'd7, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1,
                     1'b1, none});
    rows.push_back('{OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0,
                     1'b1, '{32'h0005_0000, 32'h0, 1'b0, 1'b0}});
    // the rest go through the predictor
    rows.push_back('{OP_MUL, 32'h0001_8000, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_0001,
                     1'b0, none});
    rows.push_back('{OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     1'b0, none});
    rows.push_back('{OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     1'b0, none});
    rows.push_back('{OP_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_8000, 32'hFFFF_8000,
                     1'b0, none});
    rows.push_back('{OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0, 1'b0, none});
    rows.push_back('{OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0, 1'b0, none});
    rows.push_back('{OP_DIV, 32'h0002_0000, 32'hFFFF_0000, 32'h0, 32'h0000_0001, 1'b0, none});
    rows.push_back('{OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     1'b0, none});
    rows.push_back('{OP_DIV, 32'h0000_0001, 32'h0, 32'h0000_0002, 32'h0, 1'b0, none});
    rows.push_back('{OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b0, none});
    rows.push_back('{OP_MAG, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, none});
    rows.push_back('{OP_MAG, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stimulus table
    foreach (rows[i]) begin
      res = rows[i].fixed ? rows[i].res
          : predict_cplx(rows[i].op, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi);
      send_word(rows[i].op, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi, res);
    end

    // random words, divides and multiplies weighted up
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 11))
        0, 1, 2: op = OP_DIV;
        3, 4:    op = OP_MUL;
        5:       op = OP_MAG;
        6:       op = OP_ADD;
        7:       op = OP_SUB;
        8:       op = OP_NEG;
        9:       op = OP_CONJ;
        10:      op = 3'd7;
        default: op = 3'($urandom_range(0, 7));
      endcase
      ar = rand_operand();
      ai = rand_operand();
      br = rand_operand();
      bi = ($urandom_range(0, 4) == 0) ? '0 : rand_operand();
      if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_word(op, ar, ai, br, bi, predict_cplx(op, ar, ai, br, bi));
    end
    start <= 1'b0;

    // drain, then watch for stray words
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_complex_arithmetic_unit_top: clean");
    end else begin
      $display("tb_complex_arithmetic_unit_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
